/* design/fcfs_schedule_metrics_macros.svh */
// assertion macros for the fcfs schedule metrics block
// no dependencies; included by the modules that carry assertions
`ifndef FCFS_SCHEDULE_METRICS_MACROS_SVH
`define FCFS_SCHEDULE_METRICS_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FCFSSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FCFSSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/fcfssm_pkg.sv */
// shared constants for the fcfs schedule metrics block
// no dependencies; used by the alu and the top level
`default_nettype none

package fcfssm_pkg;

    // parameter defaults
    localparam int DEF_MAX_PROCS = 16;
    localparam int DEF_TIME_BITS = 16;

    // fixed field widths of the stream words
    localparam int IN_TIME_W = 16;
    localparam int PNUM_W    = 5;
    localparam int ECHO_W    = 16;
    localparam int RES_W     = 21;
    localparam int SUM_W     = 25;

    localparam int S_TDATA_W  = 2 * IN_TIME_W;
    localparam int M_FIELDS_W = PNUM_W + 2 * ECHO_W + 4 * RES_W + 2 * SUM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // alu operation select
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

endpackage

`default_nettype wire

/* design/fcfssm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module fcfssm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/fcfssm_alu.sv */
// shared add / subtract unit with carry out (carry high on subtract = no borrow)
// depends on fcfssm_pkg
`default_nettype none

module fcfssm_alu #(
    parameter int WIDTH = 25
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic             op,
    output logic      [WIDTH-1:0] sum,
    output logic                  carry
);

    localparam int EXT_W = WIDTH + 1;

    logic [WIDTH-1:0] b_sel;

    assign b_sel = (op == fcfssm_pkg::ALU_SUB) ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_sel}
                        + EXT_W'(op == fcfssm_pkg::ALU_SUB);

endmodule

`default_nettype wire

/* design/fcfs_schedule_metrics.sv */
// top level of the fcfs schedule metrics block: sequencer, stores and stream ports
// depends on fcfssm_pkg, fcfssm_ram, fcfssm_alu and the assertion macro header
`default_nettype none
`include "fcfs_schedule_metrics_macros.svh"

// Collects up to MAX_PROCS processes, one input word each (arrival, burst), and
// numbers them from 1 in load order; words beyond capacity are dropped and flagged.
// A word with tlast closes the set: the block repeatedly scans the stored arrivals
// for the earliest unserved process (lowest number wins a tie), serves it first
// come first served with the clock idling forward to its arrival, and then emits
// one result word per process in number order, the last one with tlast. Scheduling
// repeats one selection per process: each selection is a scan through the arrival
// ram read port followed by six steps of the single shared adder. Each result then
// passes a ram read, four adder steps and the handshake, which waits out any output
// stall. Input is not taken from the closing word until the last result word has
// been accepted.
module fcfs_schedule_metrics #(
    parameter int MAX_PROCS = fcfssm_pkg::DEF_MAX_PROCS,
    parameter int TIME_BITS = fcfssm_pkg::DEF_TIME_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // arrival_time [15:0], burst_time [31:16]
    input  wire logic [fcfssm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // final_process
    input  wire logic                             s_axis_tlast,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // process_number [4:0], arrival_echo [20:5], burst_echo [36:21],
    // completion_time [57:37], turnaround_time [78:58], waiting_time [99:79],
    // response_time [120:100], turnaround_sum [145:121], waiting_sum [170:146],
    // zero fill [175:171]
    output logic      [fcfssm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // dropped_flag
    output logic                                  m_axis_tuser,
    // end_of_set
    output logic                                  m_axis_tlast
);

    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    // clock never exceeds (max arrival) + (sum of bursts)
    localparam int CLK_W     = TIME_BITS + CNT_W;
    localparam int SUM_W     = fcfssm_pkg::SUM_W;
    localparam int RES_W     = fcfssm_pkg::RES_W;
    localparam int PNUM_W    = fcfssm_pkg::PNUM_W;
    localparam int ECHO_W    = fcfssm_pkg::ECHO_W;
    localparam int IN_TIME_W = fcfssm_pkg::IN_TIME_W;
    localparam int M_PAD_W   = fcfssm_pkg::M_PAD_W;
    localparam int AW        = (CLK_W > SUM_W) ? CLK_W : SUM_W;

    // sequencer states
    localparam logic [3:0] ST_LOAD  = 4'd0;   // taking input words
    localparam logic [3:0] ST_SCAN  = 4'd1;   // search earliest unserved
    localparam logic [3:0] ST_START = 4'd2;   // start = max(clock, arrival)
    localparam logic [3:0] ST_COMP  = 4'd3;   // clock = start + burst
    localparam logic [3:0] ST_TAT   = 4'd4;   // tmp = clock - arrival
    localparam logic [3:0] ST_TTOT  = 4'd5;   // turnaround total += tmp
    localparam logic [3:0] ST_WAIT  = 4'd6;   // tmp = start - arrival
    localparam logic [3:0] ST_WTOT  = 4'd7;   // waiting total += tmp
    localparam logic [3:0] ST_ERD   = 4'd8;   // read stores for one result
    localparam logic [3:0] ST_ECOMP = 4'd9;   // completion
    localparam logic [3:0] ST_ETAT  = 4'd10;  // turnaround
    localparam logic [3:0] ST_EWAIT = 4'd11;  // waiting
    localparam logic [3:0] ST_ERESP = 4'd12;  // response
    localparam logic [3:0] ST_EOUT  = 4'd13;  // result word offered

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic [SUM_W-1:0]     ttot_reg, ttot_next;
    logic [SUM_W-1:0]     wtot_reg, wtot_next;
    logic [MAX_PROCS-1:0] served_reg, served_next;
    logic [CNT_W-1:0]     served_cnt_reg, served_cnt_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0] best_arr_reg, best_arr_next;
    logic [TIME_BITS-1:0] best_bst_reg, best_bst_next;
    logic [CLK_W-1:0]     start_reg, start_next;
    logic [CLK_W-1:0]     tmp_reg, tmp_next;
    logic [CNT_W-1:0]     emit_idx_reg, emit_idx_next;
    logic [CLK_W-1:0]     e_comp_reg, e_comp_next;
    logic [CLK_W-1:0]     e_tat_reg, e_tat_next;
    logic [CLK_W-1:0]     e_wait_reg, e_wait_next;
    logic [CLK_W-1:0]     e_resp_reg, e_resp_next;

    // store ports
    logic                 in_we;
    logic [TIME_BITS-1:0] in_arr;
    logic [TIME_BITS-1:0] in_bst;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [TIME_BITS-1:0] arr_rd;
    logic [TIME_BITS-1:0] bst_rd;
    logic [CLK_W-1:0]     st_rd;
    logic                 st_we;
    logic [CLK_W-1:0]     start_val;

    // shared adder
    logic [AW-1:0]        alu_a;
    logic [AW-1:0]        alu_b;
    logic                 alu_op;
    logic [AW-1:0]        alu_sum;
    logic                 alu_carry;

    logic                 in_acc;
    logic                 scan_issue;
    logic                 emit_last;
    logic                 set_done;

    assign in_arr = TIME_BITS'(s_axis_tdata[IN_TIME_W-1:0]);
    assign in_bst = TIME_BITS'(s_axis_tdata[2*IN_TIME_W-1:IN_TIME_W]);

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_we         = in_acc && (count_reg < CNT_W'(MAX_PROCS));

    assign scan_issue = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign rd_en      = scan_issue || (state_reg == ST_ERD);
    assign rd_addr    = (state_reg == ST_ERD) ? emit_idx_reg[IDX_W-1:0]
                                              : scan_idx_reg[IDX_W-1:0];

    // carry high on the start step means clock is not behind the arrival
    assign start_val = alu_carry ? clock_reg : CLK_W'(best_arr_reg);
    assign st_we     = (state_reg == ST_START);

    assign emit_last = (CNT_W'(emit_idx_reg + 1'b1) == count_reg);
    assign set_done  = (state_reg == ST_EOUT) && m_axis_tready && emit_last;

    fcfssm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_PROCS)
    ) u_arr_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_arr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (arr_rd)
    );

    fcfssm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_PROCS)
    ) u_bst_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_bst),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (bst_rd)
    );

    fcfssm_ram #(
        .WIDTH (CLK_W),
        .DEPTH (MAX_PROCS)
    ) u_start_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (best_idx_reg),
        .wdata (start_val),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (st_rd)
    );

    fcfssm_alu #(
        .WIDTH (AW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .op    (alu_op),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // operand routing for the shared adder
    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = fcfssm_pkg::ALU_ADD;
        unique case (state_reg)
            ST_SCAN:
            begin
                // no carry means the fresh arrival is strictly earlier
                alu_a  = AW'(arr_rd);
                alu_b  = AW'(best_arr_reg);
                alu_op = fcfssm_pkg::ALU_SUB;
            end
            ST_START, ST_TAT:
            begin
                alu_a  = AW'(clock_reg);
                alu_b  = AW'(best_arr_reg);
                alu_op = fcfssm_pkg::ALU_SUB;
            end
            ST_COMP:
            begin
                alu_a  = AW'(start_reg);
                alu_b  = AW'(best_bst_reg);
            end
            ST_TTOT:
            begin
                alu_a  = AW'(ttot_reg);
                alu_b  = AW'(tmp_reg);
            end
            ST_WAIT:
            begin
                alu_a  = AW'(start_reg);
                alu_b  = AW'(best_arr_reg);
                alu_op = fcfssm_pkg::ALU_SUB;
            end
            ST_WTOT:
            begin
                alu_a  = AW'(wtot_reg);
                alu_b  = AW'(tmp_reg);
            end
            ST_ECOMP:
            begin
                alu_a  = AW'(st_rd);
                alu_b  = AW'(bst_rd);
            end
            ST_ETAT:
            begin
                alu_a  = AW'(e_comp_reg);
                alu_b  = AW'(arr_rd);
                alu_op = fcfssm_pkg::ALU_SUB;
            end
            ST_EWAIT:
            begin
                alu_a  = AW'(e_tat_reg);
                alu_b  = AW'(bst_rd);
                alu_op = fcfssm_pkg::ALU_SUB;
            end
            ST_ERESP:
            begin
                alu_a  = AW'(st_rd);
                alu_b  = AW'(arr_rd);
                alu_op = fcfssm_pkg::ALU_SUB;
            end
            default:
            begin
                alu_op = fcfssm_pkg::ALU_ADD;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        clock_next      = clock_reg;
        ttot_next       = ttot_reg;
        wtot_next       = wtot_reg;
        served_next     = served_reg;
        served_cnt_next = served_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = scan_issue;
        rd_idx_next     = scan_idx_reg[IDX_W-1:0];
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_arr_next   = best_arr_reg;
        best_bst_next   = best_bst_reg;
        start_next      = start_reg;
        tmp_next        = tmp_reg;
        emit_idx_next   = emit_idx_reg;
        e_comp_next     = e_comp_reg;
        e_tat_next      = e_tat_reg;
        e_wait_next     = e_wait_reg;
        e_resp_next     = e_resp_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (in_we)
                    begin
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        served_next     = '0;
                        served_cnt_next = '0;
                        scan_idx_next   = '0;
                        best_vld_next   = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // data of the previous read is compared this cycle
                if (rd_vld_reg && !served_reg[rd_idx_reg] && (!best_vld_reg || !alu_carry))
                begin
                    best_vld_next = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_arr_next = arr_rd;
                    best_bst_next = bst_rd;
                end
                if (scan_issue)
                begin
                    scan_idx_next = CNT_W'(scan_idx_reg + 1'b1);
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                start_next                = start_val;
                served_next[best_idx_reg] = 1'b1;
                state_next                = ST_COMP;
            end
            ST_COMP:
            begin
                clock_next = CLK_W'(alu_sum);
                state_next = ST_TAT;
            end
            ST_TAT:
            begin
                tmp_next   = CLK_W'(alu_sum);
                state_next = ST_TTOT;
            end
            ST_TTOT:
            begin
                ttot_next  = SUM_W'(alu_sum);
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                tmp_next   = CLK_W'(alu_sum);
                state_next = ST_WTOT;
            end
            ST_WTOT:
            begin
                wtot_next       = SUM_W'(alu_sum);
                served_cnt_next = CNT_W'(served_cnt_reg + 1'b1);
                if (CNT_W'(served_cnt_reg + 1'b1) == count_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_ERD;
                end
                else
                begin
                    scan_idx_next = '0;
                    best_vld_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_ERD:
            begin
                state_next = ST_ECOMP;
            end
            ST_ECOMP:
            begin
                e_comp_next = CLK_W'(alu_sum);
                state_next  = ST_ETAT;
            end
            ST_ETAT:
            begin
                e_tat_next = CLK_W'(alu_sum);
                state_next = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                e_wait_next = CLK_W'(alu_sum);
                state_next  = ST_ERESP;
            end
            ST_ERESP:
            begin
                e_resp_next = CLK_W'(alu_sum);
                state_next  = ST_EOUT;
            end
            ST_EOUT:
            begin
                if (m_axis_tready)
                begin
                    if (emit_last)
                    begin
                        // set finished, start clean for the next one
                        count_next = '0;
                        ovf_next   = 1'b0;
                        clock_next = '0;
                        ttot_next  = '0;
                        wtot_next  = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_idx_next = CNT_W'(emit_idx_reg + 1'b1);
                        state_next    = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            clock_reg      <= '0;
            ttot_reg       <= '0;
            wtot_reg       <= '0;
            served_reg     <= '0;
            served_cnt_reg <= '0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            best_vld_reg   <= 1'b0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            clock_reg      <= clock_next;
            ttot_reg       <= ttot_next;
            wtot_reg       <= wtot_next;
            served_reg     <= served_next;
            served_cnt_reg <= served_cnt_next;
            scan_idx_reg   <= scan_idx_next;
            rd_vld_reg     <= rd_vld_next;
            best_vld_reg   <= best_vld_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_arr_reg <= best_arr_next;
        best_bst_reg <= best_bst_next;
        start_reg    <= start_next;
        tmp_reg      <= tmp_next;
        e_comp_reg   <= e_comp_next;
        e_tat_reg    <= e_tat_next;
        e_wait_reg   <= e_wait_next;
        e_resp_reg   <= e_resp_next;
    end

    // result word, all from registers and held ram read data
    assign m_axis_tvalid = (state_reg == ST_EOUT);
    assign m_axis_tdata  = {
        {M_PAD_W{1'b0}},
        wtot_reg,
        ttot_reg,
        RES_W'(e_resp_reg),
        RES_W'(e_wait_reg),
        RES_W'(e_tat_reg),
        RES_W'(e_comp_reg),
        ECHO_W'(bst_rd),
        ECHO_W'(arr_rd),
        PNUM_W'(emit_idx_reg + 1'b1)
    };
    assign m_axis_tuser  = ovf_reg;
    assign m_axis_tlast  = emit_last;

    `FCFSSM_ASSERT_IMP(a_no_result_while_loading, clk, rst_n,
        s_axis_tready, !m_axis_tvalid, "result offered while loading")
    `FCFSSM_ASSERT_IMP(a_count_in_range, clk, rst_n,
        1'b1, count_reg <= CNT_W'(MAX_PROCS), "process count beyond capacity")
    `FCFSSM_ASSERT_NXT(a_set_cleared, clk, rst_n,
        set_done, s_axis_tready && (count_reg == '0) && !ovf_reg,
        "set not cleared after last result")
    `FCFSSM_ASSERT_IMP(a_pick_unserved, clk, rst_n,
        state_reg == ST_START, best_vld_reg && !served_reg[best_idx_reg],
        "served a process twice or none")

endmodule

`default_nettype wire
